/* sv/s_curve_setpoint_generator_top_macros.svh */
// Assertion macros shared by the checker of the S-curve setpoint generator.
// Needs a clock and a reset signal named clock and reset in the using scope.
`ifndef S_CURVE_SETPOINT_GENERATOR_TOP_MACROS_SVH
`define S_CURVE_SETPOINT_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCSG_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/scsg_pkg.sv */
// Package for the S-curve setpoint generator: payload types, codes and the microprogram.
// Holds the saturating arithmetic helpers. Depends on nothing.
package scsg_pkg;

   localparam int TIME_W = 32;
   localparam int MOTION_W = 64;
   localparam int SEG_W = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int BND_W = TIME_W + 3;
   localparam int TIME_FRAC_BITS = 16;
   localparam int DIV3_W = 68;
   localparam int DIV3_DIGITS = DIV3_W / 4;

   typedef struct packed {
      logic [TIME_W-1:0] time_now;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic signed [MOTION_W-1:0] position;
      logic [SEG_W-1:0]           segment;
   } rsp_type;

   typedef enum logic [1:0] {ST_IDLE, ST_SELECT, ST_EXEC, ST_DONE} state_type;

   typedef enum logic [3:0] {
      OP_LD, OP_ST, OP_MT, OP_ADD, OP_NEG, OP_DIV2, OP_DIV3, OP_NEXT, OP_END
   } op_type;

   typedef enum logic [1:0] {T_TJ, T_TA, T_TV, T_TAU} tsel_type;

   typedef struct packed {
      op_type        op;
      logic [3:0]    rsel;
      tsel_type      tsel;
   } uinstr_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_DISTANCE = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_VELOCITY = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_ACCEL    = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_JERK     = 4'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRUISE_TIME   = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_TIME     = 4'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_JERK_TIME     = 4'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_TIME    = 4'd7;

   localparam logic [SEG_W-1:0] SEG_NONE = 4'd0;
   localparam logic [SEG_W-1:0] SEG_LAST = 4'd7;
   localparam logic [SEG_W-1:0] SEG_DONE = 4'd8;
   localparam logic [SEG_W-1:0] PROG_PRE = 4'd0;

   localparam logic [3:0] R_J    = 4'd0;
   localparam logic [3:0] R_A    = 4'd1;
   localparam logic [3:0] R_V    = 4'd2;
   localparam logic [3:0] R_D    = 4'd3;
   localparam logic [3:0] R_JT   = 4'd4;
   localparam logic [3:0] R_JT2  = 4'd5;
   localparam logic [3:0] R_JT3  = 4'd6;
   localparam logic [3:0] R_AT   = 4'd7;
   localparam logic [3:0] R_AT2  = 4'd8;
   localparam logic [3:0] R_V2   = 4'd9;
   localparam logic [3:0] R_VC   = 4'd10;
   localparam logic [3:0] R_JTA  = 4'd11;
   localparam logic [3:0] R_C3   = 4'd12;
   localparam logic [3:0] R_C4   = 4'd13;
   localparam logic [3:0] R_MVTV = 4'd14;
   localparam logic [3:0] R_X    = 4'd15;

   localparam logic signed [MOTION_W-1:0] S64_MAX = {1'b0, {(MOTION_W-1){1'b1}}};
   localparam logic signed [MOTION_W-1:0] S64_MIN = {1'b1, {(MOTION_W-1){1'b0}}};

   function automatic logic signed [MOTION_W-1:0] sadd(input logic signed [MOTION_W-1:0] a,
                                                       input logic signed [MOTION_W-1:0] b);
      logic signed [MOTION_W:0] s;
      s = {a[MOTION_W-1], a} + {b[MOTION_W-1], b};
      if (s[MOTION_W] != s[MOTION_W-1]) begin
         return s[MOTION_W] ? S64_MIN : S64_MAX;
      end
      return s[MOTION_W-1:0];
   endfunction

   function automatic logic signed [MOTION_W-1:0] sneg(input logic signed [MOTION_W-1:0] a);
      if (a == S64_MIN) begin
         return S64_MAX;
      end
      return -a;
   endfunction

   // Four restoring steps of a divide by three; returns quotient nibble and remainder.
   function automatic logic [5:0] div3_nib(input logic [1:0] r, input logic [3:0] d);
      logic [2:0] rr;
      logic [3:0] q;
      rr = {1'b0, r};
      q = '0;
      for (int i = 3; i >= 0; i--) begin
         rr = {rr[1:0], d[i]};
         if (rr >= 3'd3) begin
            rr = rr - 3'd3;
            q[i] = 1'b1;
         end
      end
      return {q, rr[1:0]};
   endfunction

   function automatic uinstr_type i_ld(input logic [3:0] r);
      return '{op: OP_LD, rsel: r, tsel: T_TAU};
   endfunction

   function automatic uinstr_type i_st(input logic [3:0] r);
      return '{op: OP_ST, rsel: r, tsel: T_TAU};
   endfunction

   function automatic uinstr_type i_add(input logic [3:0] r);
      return '{op: OP_ADD, rsel: r, tsel: T_TAU};
   endfunction

   function automatic uinstr_type i_mt(input tsel_type t);
      return '{op: OP_MT, rsel: R_X, tsel: t};
   endfunction

   function automatic uinstr_type i_op(input op_type o);
      return '{op: o, rsel: R_X, tsel: T_TAU};
   endfunction

   // Microprogram: program 0 computes the shared terms, programs 1 to 7 the segments, program 8 the finished move.
   function automatic uinstr_type ucode(input logic [SEG_W-1:0] prog, input logic [5:0] step);
      uinstr_type u;
      u = i_op(OP_END);
      case (prog)
         4'd0: begin
            case (step)
               6'd0: u = i_ld(R_J);     6'd1: u = i_mt(T_TJ);   6'd2: u = i_st(R_JT);
               6'd3: u = i_mt(T_TJ);    6'd4: u = i_st(R_JT2);  6'd5: u = i_mt(T_TJ);
               6'd6: u = i_st(R_JT3);   6'd7: u = i_ld(R_A);    6'd8: u = i_mt(T_TA);
               6'd9: u = i_st(R_AT);    6'd10: u = i_mt(T_TA);  6'd11: u = i_st(R_AT2);
               6'd12: u = i_ld(R_JT2);  6'd13: u = i_op(OP_DIV2); 6'd14: u = i_add(R_AT);
               6'd15: u = i_st(R_V2);   6'd16: u = i_ld(R_AT);  6'd17: u = i_add(R_JT2);
               6'd18: u = i_st(R_VC);   6'd19: u = i_ld(R_JT2); 6'd20: u = i_mt(T_TA);
               6'd21: u = i_op(OP_DIV2); 6'd22: u = i_st(R_JTA); 6'd23: u = i_ld(R_V2);
               6'd24: u = i_mt(T_TJ);   6'd25: u = i_st(R_X);   6'd26: u = i_ld(R_AT2);
               6'd27: u = i_op(OP_DIV2); 6'd28: u = i_add(R_X); 6'd29: u = i_add(R_JTA);
               6'd30: u = i_st(R_C3);   6'd31: u = i_ld(R_V);   6'd32: u = i_mt(T_TV);
               6'd33: u = i_st(R_MVTV); 6'd34: u = i_add(R_C3); 6'd35: u = i_st(R_C4);
               6'd36: u = i_op(OP_NEXT);
               default: u = i_op(OP_END);
            endcase
         end
         4'd1: begin
            case (step)
               6'd0: u = i_ld(R_J);     6'd1: u = i_mt(T_TAU);  6'd2: u = i_mt(T_TAU);
               6'd3: u = i_mt(T_TAU);   6'd4: u = i_op(OP_DIV2); 6'd5: u = i_op(OP_DIV3);
               default: u = i_op(OP_END);
            endcase
         end
         4'd2: begin
            case (step)
               6'd0: u = i_ld(R_JT2);   6'd1: u = i_mt(T_TAU);  6'd2: u = i_op(OP_DIV2);
               6'd3: u = i_st(R_X);     6'd4: u = i_ld(R_A);    6'd5: u = i_mt(T_TAU);
               6'd6: u = i_mt(T_TAU);   6'd7: u = i_op(OP_DIV2); 6'd8: u = i_add(R_X);
               6'd9: u = i_st(R_X);     6'd10: u = i_ld(R_JT3); 6'd11: u = i_op(OP_DIV2);
               6'd12: u = i_op(OP_DIV3); 6'd13: u = i_add(R_X);
               default: u = i_op(OP_END);
            endcase
         end
         4'd3: begin
            case (step)
               6'd0: u = i_ld(R_JT);    6'd1: u = i_mt(T_TAU);  6'd2: u = i_mt(T_TAU);
               6'd3: u = i_op(OP_DIV2); 6'd4: u = i_st(R_X);    6'd5: u = i_ld(R_J);
               6'd6: u = i_mt(T_TAU);   6'd7: u = i_mt(T_TAU);  6'd8: u = i_mt(T_TAU);
               6'd9: u = i_op(OP_DIV2); 6'd10: u = i_op(OP_DIV3); 6'd11: u = i_op(OP_NEG);
               6'd12: u = i_add(R_X);   6'd13: u = i_st(R_X);   6'd14: u = i_ld(R_V2);
               6'd15: u = i_mt(T_TAU);  6'd16: u = i_add(R_X);  6'd17: u = i_st(R_X);
               6'd18: u = i_ld(R_AT2);  6'd19: u = i_op(OP_DIV2); 6'd20: u = i_add(R_X);
               6'd21: u = i_add(R_JTA); 6'd22: u = i_st(R_X);   6'd23: u = i_ld(R_JT3);
               6'd24: u = i_op(OP_DIV2); 6'd25: u = i_op(OP_DIV3); 6'd26: u = i_add(R_X);
               default: u = i_op(OP_END);
            endcase
         end
         4'd4: begin
            case (step)
               6'd0: u = i_ld(R_V);     6'd1: u = i_mt(T_TAU);  6'd2: u = i_add(R_C3);
               6'd3: u = i_st(R_X);     6'd4: u = i_ld(R_JT3);  6'd5: u = i_op(OP_DIV2);
               6'd6: u = i_add(R_X);
               default: u = i_op(OP_END);
            endcase
         end
         4'd5: begin
            case (step)
               6'd0: u = i_ld(R_VC);    6'd1: u = i_mt(T_TAU);  6'd2: u = i_st(R_X);
               6'd3: u = i_ld(R_J);     6'd4: u = i_mt(T_TAU);  6'd5: u = i_mt(T_TAU);
               6'd6: u = i_mt(T_TAU);   6'd7: u = i_op(OP_DIV2); 6'd8: u = i_op(OP_DIV3);
               6'd9: u = i_op(OP_NEG);  6'd10: u = i_add(R_X);  6'd11: u = i_add(R_C4);
               6'd12: u = i_st(R_X);    6'd13: u = i_ld(R_JT3); 6'd14: u = i_op(OP_DIV2);
               6'd15: u = i_add(R_X);
               default: u = i_op(OP_END);
            endcase
         end
         4'd6: begin
            case (step)
               6'd0: u = i_ld(R_V2);    6'd1: u = i_mt(T_TAU);  6'd2: u = i_st(R_X);
               6'd3: u = i_ld(R_A);     6'd4: u = i_mt(T_TAU);  6'd5: u = i_mt(T_TAU);
               6'd6: u = i_op(OP_DIV2); 6'd7: u = i_op(OP_NEG); 6'd8: u = i_add(R_X);
               6'd9: u = i_add(R_C4);   6'd10: u = i_st(R_X);   6'd11: u = i_ld(R_VC);
               6'd12: u = i_mt(T_TJ);   6'd13: u = i_add(R_X);  6'd14: u = i_st(R_X);
               6'd15: u = i_ld(R_JT3);  6'd16: u = i_op(OP_DIV3); 6'd17: u = i_add(R_X);
               default: u = i_op(OP_END);
            endcase
         end
         4'd7: begin
            case (step)
               6'd0: u = i_ld(R_JT);    6'd1: u = i_mt(T_TAU);  6'd2: u = i_mt(T_TAU);
               6'd3: u = i_op(OP_DIV2); 6'd4: u = i_op(OP_NEG); 6'd5: u = i_st(R_X);
               6'd6: u = i_ld(R_J);     6'd7: u = i_mt(T_TAU);  6'd8: u = i_mt(T_TAU);
               6'd9: u = i_mt(T_TAU);   6'd10: u = i_op(OP_DIV2); 6'd11: u = i_op(OP_DIV3);
               6'd12: u = i_add(R_X);   6'd13: u = i_st(R_X);   6'd14: u = i_ld(R_JT2);
               6'd15: u = i_mt(T_TAU);  6'd16: u = i_op(OP_DIV2); 6'd17: u = i_add(R_X);
               6'd18: u = i_st(R_X);    6'd19: u = i_ld(R_V2);  6'd20: u = i_mt(T_TA);
               6'd21: u = i_add(R_X);   6'd22: u = i_st(R_X);   6'd23: u = i_ld(R_V2);
               6'd24: u = i_mt(T_TJ);   6'd25: u = i_add(R_X);  6'd26: u = i_st(R_X);
               6'd27: u = i_ld(R_VC);   6'd28: u = i_mt(T_TJ);  6'd29: u = i_add(R_X);
               6'd30: u = i_add(R_MVTV); 6'd31: u = i_add(R_JTA); 6'd32: u = i_st(R_X);
               6'd33: u = i_ld(R_JT3);  6'd34: u = i_op(OP_DIV3); 6'd35: u = i_add(R_X);
               default: u = i_op(OP_END);
            endcase
         end
         default: begin
            case (step)
               6'd0: u = i_ld(R_D);
               default: u = i_op(OP_END);
            endcase
         end
      endcase
      return u;
   endfunction

endpackage

/* sv/s_curve_setpoint_generator_top.sv */
// Seven-segment S-curve position setpoint generator, top level.
// Depends on scsg_pkg. A microcoded sequencer drives one shared arithmetic unit.
//
// Usage: write the move through the csr_ port (index 0 distance, 1 velocity,
// 2 acceleration, 3 jerk, 4 cruise time, 5 hold time, 6 jerk time, 7 start
// time) while the block is idle. Each req_ transaction carries a time sample
// and a restart flag; each produces exactly one rsp_ transaction with the
// position setpoint and the active segment (8 when the move is finished).
// The block works on one transaction at a time: after acceptance req_ready
// stays low until the result is loaded into the output register.
// For a sample outside the move the segment search is followed by a program
// that only loads the distance; inside it, by the full microprogram, where
// each multiply is built from a 32x32 unsigned and a 32x33 signed partial
// product and each divide by three works at 4 bits per cycle. A new
// request is taken while an earlier result still waits in the output
// register; if the receiver stalls, the next result waits inside.
// Synchronous reset clears the CSRs, the state, the kept segment and the result valid.
module s_curve_setpoint_generator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scsg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scsg_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [3:0]        csr_addr,
   input  logic [63:0]       csr_wdata
);
   import scsg_pkg::*;

   logic signed [MOTION_W-1:0] dist_ff, vel_ff, accel_ff, jerk_ff;
   logic [TIME_W-1:0] tv_ff, ta_ff, tj_ff, ts_ff;

   state_type state_ff, state_in;
   logic [SEG_W-1:0] prog_ff, prog_in, seg_ff, seg_in, cur_ff, cur_in;
   logic [5:0] step_ff, step_in;
   logic [4:0] sub_ff, sub_in;
   logic [2:0] k_ff, k_in;
   logic [BND_W-1:0] lo_ff, lo_in;
   logic [TIME_W-1:0] t_ff, t_in, tau_ff, tau_in;
   logic signed [MOTION_W-1:0] acc_ff, acc_in;
   logic signed [MOTION_W-1:0] tmp_ff [16];
   logic signed [MOTION_W-1:0] tmp_in [16];
   logic [63:0] plo_ff, plo_in;
   logic signed [64:0] phi_ff, phi_in;
   logic [DIV3_W-1:0] dq_ff, dq_in;
   logic [1:0] rem_ff, rem_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   uinstr_type u;
   logic signed [MOTION_W-1:0] rd;
   logic [TIME_W-1:0] xval, dur;
   logic [BND_W-1:0] hi, t_ext;
   logic hit;
   logic [63:0] mul_lo;
   logic signed [31:0] a_hi;
   logic signed [32:0] x_s;
   logic signed [64:0] mul_hi;
   logic signed [96:0] full;
   logic signed [MOTION_W-1:0] mt_sat;
   logic [5:0] nib;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
         vel_ff <= '0;
         accel_ff <= '0;
         jerk_ff <= '0;
         tv_ff <= '0;
         ta_ff <= '0;
         tj_ff <= '0;
         ts_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PEAK_DISTANCE: dist_ff <= csr_wdata;
            CSR_PEAK_VELOCITY: vel_ff <= csr_wdata;
            CSR_PEAK_ACCEL: accel_ff <= csr_wdata;
            CSR_PEAK_JERK: jerk_ff <= csr_wdata;
            CSR_CRUISE_TIME: tv_ff <= csr_wdata[TIME_W-1:0];
            CSR_HOLD_TIME: ta_ff <= csr_wdata[TIME_W-1:0];
            CSR_JERK_TIME: tj_ff <= csr_wdata[TIME_W-1:0];
            CSR_START_TIME: ts_ff <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= SEG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prog_ff <= prog_in;
      seg_ff <= seg_in;
      step_ff <= step_in;
      sub_ff <= sub_in;
      k_ff <= k_in;
      lo_ff <= lo_in;
      t_ff <= t_in;
      tau_ff <= tau_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      u = ucode(prog_ff, step_ff);

      unique case (u.rsel)
         R_J: rd = jerk_ff;
         R_A: rd = accel_ff;
         R_V: rd = vel_ff;
         R_D: rd = dist_ff;
         default: rd = tmp_ff[u.rsel];
      endcase

      unique case (u.tsel)
         T_TJ: xval = tj_ff;
         T_TA: xval = ta_ff;
         T_TV: xval = tv_ff;
         T_TAU: xval = tau_ff;
      endcase

      mul_lo = {32'b0, acc_ff[31:0]} * {32'b0, xval};
      a_hi = acc_ff[63:32];
      x_s = {1'b0, xval};
      mul_hi = a_hi * x_s;
      full = {phi_ff, 32'b0} + {33'b0, plo_ff};
      if (full[96:79] == '0 || full[96:79] == '1) begin
         mt_sat = full[79:16];
      end else begin
         mt_sat = full[96] ? S64_MIN : S64_MAX;
      end
      nib = div3_nib(rem_ff, dq_ff[DIV3_W-1:DIV3_W-4]);

      unique case (k_ff)
         3'd2, 3'd6: dur = ta_ff;
         3'd4: dur = tv_ff;
         default: dur = tj_ff;
      endcase
      hi = lo_ff + {3'b0, dur};
      t_ext = {3'b0, t_ff};
      hit = (lo_ff <= t_ext) && (t_ext <= hi) && (cur_ff <= {1'b0, k_ff});

      state_in = state_ff;
      prog_in = prog_ff;
      seg_in = seg_ff;
      cur_in = cur_ff;
      step_in = step_ff;
      sub_in = sub_ff;
      k_in = k_ff;
      lo_in = lo_ff;
      t_in = t_ff;
      tau_in = tau_ff;
      acc_in = acc_ff;
      tmp_in = tmp_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               t_in = req_data.time_now;
               if (req_data.restart) begin
                  cur_in = SEG_NONE;
               end
               lo_in = {3'b0, ts_ff};
               k_in = 3'd1;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            step_in = '0;
            sub_in = '0;
            if (hit) begin
               seg_in = {1'b0, k_ff};
               cur_in = {1'b0, k_ff};
               tau_in = t_ff - lo_ff[TIME_W-1:0];
               prog_in = PROG_PRE;
               state_in = ST_EXEC;
            end else if ({1'b0, k_ff} == SEG_LAST) begin
               seg_in = SEG_DONE;
               cur_in = SEG_DONE;
               prog_in = SEG_DONE;
               state_in = ST_EXEC;
            end else begin
               lo_in = hi;
               k_in = k_ff + 3'd1;
            end
         end
         ST_EXEC: begin
            unique case (u.op)
               OP_LD: begin
                  acc_in = rd;
                  step_in = step_ff + 6'd1;
               end
               OP_ST: begin
                  tmp_in[u.rsel] = acc_ff;
                  step_in = step_ff + 6'd1;
               end
               OP_ADD: begin
                  acc_in = sadd(acc_ff, rd);
                  step_in = step_ff + 6'd1;
               end
               OP_NEG: begin
                  acc_in = sneg(acc_ff);
                  step_in = step_ff + 6'd1;
               end
               OP_DIV2: begin
                  acc_in = acc_ff >>> 1;
                  step_in = step_ff + 6'd1;
               end
               OP_MT: begin
                  priority case (sub_ff)
                     5'd0: begin
                        plo_in = mul_lo;
                        sub_in = 5'd1;
                     end
                     5'd1: begin
                        phi_in = mul_hi;
                        sub_in = 5'd2;
                     end
                     default: begin
                        acc_in = mt_sat;
                        sub_in = '0;
                        step_in = step_ff + 6'd1;
                     end
                  endcase
               end
               OP_DIV3: begin
                  if (sub_ff == '0) begin
                     // Bias by three times 2^63 so the dividend is non-negative.
                     dq_in = {{4{acc_ff[63]}}, acc_ff} + {4'b0001, 64'b0} + {5'b00001, 63'b0};
                     rem_in = '0;
                     sub_in = 5'd1;
                  end else if (sub_ff <= 5'(DIV3_DIGITS)) begin
                     dq_in = {dq_ff[DIV3_W-5:0], nib[5:2]};
                     rem_in = nib[1:0];
                     sub_in = sub_ff + 5'd1;
                  end else begin
                     acc_in = {~dq_ff[63], dq_ff[62:0]};
                     sub_in = '0;
                     step_in = step_ff + 6'd1;
                  end
               end
               OP_NEXT: begin
                  prog_in = seg_ff;
                  step_in = '0;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.position = acc_ff;
               rsp_in.segment = seg_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* sv/scsg_checker.sv */
// Port-level checker for the S-curve setpoint generator, bound to its top level.
// Depends on scsg_pkg and s_curve_setpoint_generator_top_macros.svh.
`include "s_curve_setpoint_generator_top_macros.svh"

module scsg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scsg_pkg::rsp_type rsp_data
);
   import scsg_pkg::*;

   `SCSG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result transaction changed or dropped")
   `SCSG_ASSERT_IMPL(a_seg_range, rsp_valid, rsp_data.segment >= 4'd1 && rsp_data.segment <= SEG_DONE, "segment out of range")
   `SCSG_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "request taken while a transaction is in progress")

endmodule

bind s_curve_setpoint_generator_top scsg_checker u_scsg_checker (.*);
